// ----- hw/rtl/mecanum_dead_reckoning_pose_defines.svh -----
// Assertion macros for the mecanum pose estimator.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef MECANUM_DEAD_RECKONING_POSE_DEFINES_SVH
`define MECANUM_DEAD_RECKONING_POSE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MDR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdr: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdr: next-cycle check failed");

`endif

// ----- hw/rtl/mdr_pkg.sv -----
// Shared constants, command codes and helper functions for the mecanum pose estimator.
// No dependencies.
package mdr_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int CORDIC_STEPS  = 24;
    localparam int CNT_W         = 5;

    localparam logic [1:0] CMD_ENCODER   = 2'd0;
    localparam logic [1:0] CMD_GYRO      = 2'd1;
    localparam logic [1:0] CMD_CLR_WORLD = 2'd2;
    localparam logic [1:0] CMD_CLR_MOVE  = 2'd3;

    localparam logic [1:0] REG_WHEEL_RADIUS  = 2'd0;
    localparam logic [1:0] REG_RAD_PER_TICK  = 2'd1;
    localparam logic [1:0] REG_GYRO_BIAS     = 2'd2;
    localparam logic [1:0] REG_GYRO_DEADBAND = 2'd3;

    localparam logic [23:0] WHEEL_RADIUS_RST = 24'd671089;
    localparam logic [23:0] RAD_PER_TICK_RST = 24'd21085;
    localparam logic [15:0] DEADBAND_RST     = 16'd154;

    // Angles in Q30
    localparam logic [32:0] Q30_PI      = 33'd3373259426;
    localparam logic [32:0] Q30_HALF_PI = 33'd1686629713;
    localparam logic [32:0] Q30_TWO_PI  = 33'd6746518852;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // pi / (180 * 1024 * 1e6) in Q60
    localparam logic [31:0] RATE_SCALE  = 32'd19650661;
    localparam logic [31:0] DT_DEFAULT  = 32'd20000;
    localparam logic [31:0] DT_LIMIT    = 32'd500000;

    localparam logic [50:0] PRODUCT_CAP = 51'h4_0000_0000_0000;

    localparam logic signed [53:0] SAT48_HI = 54'sh00_7FFF_FFFF_FFFF;
    localparam logic signed [53:0] SAT48_LO = -SAT48_HI - 54'sd1;
    localparam logic signed [53:0] SAT40_HI = 54'sh00_007F_FFFF_FFFF;
    localparam logic signed [53:0] SAT40_LO = -SAT40_HI - 54'sd1;

    function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd843314857;
            5'd1:    r = 32'd497837829;
            5'd2:    r = 32'd263043837;
            5'd3:    r = 32'd133525159;
            5'd4:    r = 32'd67021687;
            5'd5:    r = 32'd33543515;
            5'd6:    r = 32'd16775851;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194283;
            5'd9:    r = 32'd2097149;
            5'd10:   r = 32'd1048576;
            5'd11:   r = 32'd524288;
            5'd12:   r = 32'd262144;
            5'd13:   r = 32'd131072;
            5'd14:   r = 32'd65536;
            5'd15:   r = 32'd32768;
            5'd16:   r = 32'd16384;
            5'd17:   r = 32'd8192;
            5'd18:   r = 32'd4096;
            5'd19:   r = 32'd2048;
            5'd20:   r = 32'd1024;
            5'd21:   r = 32'd512;
            5'd22:   r = 32'd256;
            5'd23:   r = 32'd128;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        logic signed [53:0] r;
        if (v > SAT48_HI)
            r = SAT48_HI;
        else if (v < SAT48_LO)
            r = SAT48_LO;
        else
            r = v;
        return r[47:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [53:0] v);
        logic signed [53:0] r;
        if (v > SAT40_HI)
            r = SAT40_HI;
        else if (v < SAT40_LO)
            r = SAT40_LO;
        else
            r = v;
        return r[39:0];
    endfunction

endpackage

// ----- hw/rtl/mecanum_dead_reckoning_pose.sv -----
// Mecanum dead-reckoning pose estimator: sequencer, shared multiplier, reduction and CORDIC.
// Depends on mdr_pkg and mecanum_dead_reckoning_pose_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: an encoder sample,
//   a gyro sample, a clear of the world position or a clear of the local trackers.
//   Every input beat yields exactly one output beat (out_valid/out_ready) holding
//   heading, world_x/world_y and move_x/move_y as they stand after the command.
//   One 32x32 multiplier is reused for every product; a wide product goes through
//   it in order (low half, high half, accumulate, shift and cap).
//   An encoder beat runs four wheel products, the yaw angle reduction, 24 CORDIC
//   iterations and four rotation products, all on the one multiplier or the
//   add/shift path. in_ready is high only while idle, so the next beat is taken
//   only once the sequencer has handed the last result to the output register.
//   The finished result sits in an output register; the next beat is taken while
//   it waits. If the receiver stalls, the following result holds in the sequencer
//   until the output register frees up.
//   Reset clears the pose, trackers, last counts and last gyro time, and loads the
//   register defaults. Configuration writes (cfg_write) are registered directly and are
//   meant to happen only while idle.
`include "mecanum_dead_reckoning_pose_defines.svh"

module mecanum_dead_reckoning_pose #(
    parameter int FRAC_BITS = mdr_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic signed [31:0]  count_a,
    input  logic signed [31:0]  count_b,
    input  logic signed [31:0]  count_c,
    input  logic signed [31:0]  count_d,
    input  logic signed [21:0]  gyro_rate,
    input  logic [31:0]         timestamp_us,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [39:0]  heading,
    output logic signed [47:0]  world_x,
    output logic signed [47:0]  world_y,
    output logic signed [47:0]  move_x,
    output logic signed [47:0]  move_y
);
    import mdr_pkg::*;

    // Width of |yaw| once scaled to Q30
    localparam int MAG_W = 70 - FRAC_BITS;
    localparam int YAW_SHL = 30 - FRAC_BITS;
    localparam int SH_WHEEL_AMT = FRAC_BITS + 2;
    localparam int SH_ROT_AMT = 30;
    localparam int SH_YAW_AMT = 60 - FRAC_BITS;
    localparam logic [CNT_W-1:0] RED_TOP = CNT_W'(MAG_W - 33);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic signed [34:0] Z_PI = 35'(Q30_PI);
    localparam logic signed [34:0] Z_HALF = 35'(Q30_HALF_PI);
    localparam logic signed [34:0] Z_TWO_PI = 35'(Q30_TWO_PI);

    typedef enum logic [24:0] {
        S_IDLE     = 25'h0000001,
        S_E_X1     = 25'h0000002,
        S_E_X2     = 25'h0000004,
        S_E_X3     = 25'h0000008,
        S_E_Y2     = 25'h0000010,
        S_E_Y3     = 25'h0000020,
        S_R_STEP   = 25'h0000040,
        S_R_SIGN   = 25'h0000080,
        S_R_WRAP   = 25'h0000100,
        S_R_FOLD   = 25'h0000200,
        S_C_STEP   = 25'h0000400,
        S_C_DONE   = 25'h0000800,
        S_G1       = 25'h0001000,
        S_G2       = 25'h0002000,
        S_G3       = 25'h0004000,
        S_G4       = 25'h0008000,
        S_G5       = 25'h0010000,
        S_GY_PREP  = 25'h0020000,
        S_GY_SCALE = 25'h0040000,
        S_GY_ADD   = 25'h0080000,
        S_MUL0     = 25'h0100000,
        S_MUL1     = 25'h0200000,
        S_MUL2     = 25'h0400000,
        S_MUL3     = 25'h0800000,
        S_DONE     = 25'h1000000
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_WHEEL,
        SH_ROT,
        SH_YAW
    } shift_sel_t;

    // Sequencer
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // Configuration
    logic [23:0] wr_reg, wr_next;
    logic [23:0] rpt_reg, rpt_next;
    logic signed [21:0] bias_reg, bias_next;
    logic [15:0] db_reg, db_next;

    // Architectural state
    logic [31:0] last_cnt_reg [4];
    logic [31:0] last_cnt_next [4];
    logic signed [39:0] yaw_reg, yaw_next;
    logic signed [47:0] px_reg, px_next;
    logic signed [47:0] py_reg, py_next;
    logic signed [47:0] lx_reg, lx_next;
    logic signed [47:0] ly_reg, ly_next;
    logic [31:0] last_t_reg, last_t_next;

    // Output register
    logic out_valid_reg, out_valid_next;
    logic signed [39:0] heading_reg, heading_next;
    logic signed [47:0] wx_reg, wx_next;
    logic signed [47:0] wy_reg, wy_next;
    logic signed [47:0] mx_reg, mx_next;
    logic signed [47:0] my_reg, my_next;

    // Working registers
    logic signed [33:0] tx_reg, tx_next;
    logic signed [33:0] ty_reg, ty_next;
    logic signed [51:0] dx_reg, dx_next;
    logic signed [51:0] dy_reg, dy_next;
    logic signed [51:0] t_reg, t_next;
    logic signed [47:0] g_reg, g_next;
    logic signed [22:0] c_reg, c_next;
    logic [31:0] dt_reg, dt_next;
    logic [MAG_W-1:0] m_reg, m_next;
    logic zneg_reg, zneg_next;
    logic signed [34:0] z_reg, z_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic flip_reg, flip_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Shared multiplier
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic neg_reg, neg_next;
    shift_sel_t sh_reg, sh_next;
    logic [63:0] mp_reg, mp_next;
    logic [95:0] p_reg, p_next;
    logic [63:0] q_reg, q_next;

    // Combinational helpers
    logic [31:0] cur [4];
    logic signed [31:0] dlt [4];
    logic signed [33:0] sum_x, sum_y;
    logic [31:0] mul_in;
    logic [95:0] p_sh;
    logic signed [51:0] sq;
    logic [MAG_W-1:0] tp_k;
    logic signed [MAG_W:0] yaw_sc, yaw_abs;
    logic [33:0] tx_mag, ty_mag;
    logic [51:0] dx_mag, dy_mag;
    logic [31:0] cos_mag, sin_mag;
    logic signed [33:0] x_sh, y_sh;
    logic signed [34:0] atan_z;
    logic signed [34:0] zm;
    logic [22:0] c_abs;
    logic dead;
    logic [31:0] dt_fix;

    assign cur[0] = count_a;
    assign cur[1] = count_b;
    assign cur[2] = count_c;
    assign cur[3] = count_d;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dlt[i] = $signed(last_cnt_reg[i] - cur[i]);
        end
    end

    assign sum_x = 34'(dlt[0]) + 34'(dlt[1]) + 34'(dlt[2]) + 34'(dlt[3]);
    assign sum_y = 34'(dlt[0]) - 34'(dlt[1]) - 34'(dlt[2]) + 34'(dlt[3]);

    // One multiplier, fed the low then the high half of the magnitude operand
    assign mul_in = (state_reg == S_MUL0) ? a_reg[31:0] : a_reg[63:32];

    always_comb
    begin
        case (sh_reg)
            SH_NONE:  p_sh = p_reg;
            SH_WHEEL: p_sh = p_reg >> SH_WHEEL_AMT;
            SH_ROT:   p_sh = p_reg >> SH_ROT_AMT;
            SH_YAW:   p_sh = p_reg >> SH_YAW_AMT;
            default:  p_sh = p_reg;
        endcase
    end

    // Capped product magnitude with its sign applied
    assign sq = neg_reg ? -$signed({1'b0, q_reg[50:0]}) : $signed({1'b0, q_reg[50:0]});

    assign tp_k = MAG_W'(Q30_TWO_PI) << cnt_reg;
    assign yaw_sc = (MAG_W + 1)'(yaw_reg) <<< YAW_SHL;
    assign yaw_abs = yaw_sc[MAG_W] ? -yaw_sc : yaw_sc;

    assign tx_mag = tx_reg[33] ? 34'(-tx_reg) : 34'(tx_reg);
    assign ty_mag = ty_reg[33] ? 34'(-ty_reg) : 34'(ty_reg);
    assign dx_mag = dx_reg[51] ? 52'(-dx_reg) : 52'(dx_reg);
    assign dy_mag = dy_reg[51] ? 52'(-dy_reg) : 52'(dy_reg);
    assign cos_mag = x_reg[33] ? 32'(-x_reg) : 32'(x_reg);
    assign sin_mag = y_reg[33] ? 32'(-y_reg) : 32'(y_reg);

    assign x_sh = x_reg >>> cnt_reg;
    assign y_sh = y_reg >>> cnt_reg;
    assign atan_z = signed'(35'(atan_q30(cnt_reg)));
    assign zm = signed'({2'b00, m_reg[32:0]});

    assign c_abs = c_reg[22] ? 23'(-c_reg) : 23'(c_reg);
    assign dead = c_abs < {7'd0, db_reg};
    assign dt_fix = ((dt_reg == '0) || (dt_reg > DT_LIMIT)) ? DT_DEFAULT : dt_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        wr_next = wr_reg;
        rpt_next = rpt_reg;
        bias_next = bias_reg;
        db_next = db_reg;
        for (int i = 0; i < 4; i++)
        begin
            last_cnt_next[i] = last_cnt_reg[i];
        end
        yaw_next = yaw_reg;
        px_next = px_reg;
        py_next = py_reg;
        lx_next = lx_reg;
        ly_next = ly_reg;
        last_t_next = last_t_reg;
        out_valid_next = out_valid_reg;
        heading_next = heading_reg;
        wx_next = wx_reg;
        wy_next = wy_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        t_next = t_reg;
        g_next = g_reg;
        c_next = c_reg;
        dt_next = dt_reg;
        m_next = m_reg;
        zneg_next = zneg_reg;
        z_next = z_reg;
        x_next = x_reg;
        y_next = y_reg;
        flip_next = flip_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        neg_next = neg_reg;
        sh_next = sh_reg;
        mp_next = mp_reg;
        p_next = p_reg;
        q_next = q_reg;

        // Register writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WHEEL_RADIUS:  wr_next = cfg_data;
                REG_RAD_PER_TICK:  rpt_next = cfg_data;
                REG_GYRO_BIAS:     bias_next = signed'(cfg_data[21:0]);
                REG_GYRO_DEADBAND: db_next = cfg_data[15:0];
                default:           wr_next = wr_reg;
            endcase
        end

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_ENCODER:
                        begin
                            tx_next = sum_x;
                            ty_next = sum_y;
                            for (int i = 0; i < 4; i++)
                            begin
                                last_cnt_next[i] = cur[i];
                            end
                            state_next = S_E_X1;
                        end
                        CMD_GYRO:
                        begin
                            c_next = 23'(gyro_rate) - 23'(bias_reg);
                            dt_next = timestamp_us - last_t_reg;
                            last_t_next = timestamp_us;
                            state_next = S_GY_PREP;
                        end
                        CMD_CLR_WORLD:
                        begin
                            px_next = '0;
                            py_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            lx_next = '0;
                            ly_next = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Wheel mix: |sum| * rad/tick, then * radius >> (F+2)
            S_E_X1:
            begin
                a_next = 64'(tx_mag);
                b_next = 32'(rpt_reg);
                neg_next = tx_reg[33];
                sh_next = SH_NONE;
                ret_next = S_E_X2;
                state_next = S_MUL0;
            end
            S_E_X2:
            begin
                a_next = q_reg;
                b_next = 32'(wr_reg);
                sh_next = SH_WHEEL;
                ret_next = S_E_X3;
                state_next = S_MUL0;
            end
            S_E_X3:
            begin
                dx_next = sq;
                a_next = 64'(ty_mag);
                b_next = 32'(rpt_reg);
                neg_next = ty_reg[33];
                sh_next = SH_NONE;
                ret_next = S_E_Y2;
                state_next = S_MUL0;
            end
            S_E_Y2:
            begin
                a_next = q_reg;
                b_next = 32'(wr_reg);
                sh_next = SH_WHEEL;
                ret_next = S_E_Y3;
                state_next = S_MUL0;
            end
            S_E_Y3:
            begin
                dy_next = sq;
                lx_next = sat48(54'(lx_reg) + 54'(dx_reg));
                ly_next = sat48(54'(ly_reg) + 54'(sq));
                // Start reducing |yaw| in Q30 modulo two pi
                m_next = yaw_abs[MAG_W-1:0];
                zneg_next = yaw_sc[MAG_W];
                cnt_next = RED_TOP;
                state_next = S_R_STEP;
            end

            // One restoring subtract of 2*pi<<k per cycle
            S_R_STEP:
            begin
                if (m_reg >= tp_k)
                begin
                    m_next = m_reg - tp_k;
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_R_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_R_SIGN:
            begin
                z_next = zneg_reg ? -zm : zm;
                state_next = S_R_WRAP;
            end
            S_R_WRAP:
            begin
                if (z_reg > Z_PI)
                begin
                    z_next = z_reg - Z_TWO_PI;
                end
                else if (z_reg < -Z_PI)
                begin
                    z_next = z_reg + Z_TWO_PI;
                end
                state_next = S_R_FOLD;
            end
            S_R_FOLD:
            begin
                flip_next = 1'b0;
                if (z_reg > Z_HALF)
                begin
                    z_next = z_reg - Z_PI;
                    flip_next = 1'b1;
                end
                else if (z_reg < -Z_HALF)
                begin
                    z_next = z_reg + Z_PI;
                    flip_next = 1'b1;
                end
                x_next = 34'(CORDIC_GAIN);
                y_next = '0;
                cnt_next = '0;
                state_next = S_C_STEP;
            end

            // Rotation-mode CORDIC, one micro-rotation per cycle
            S_C_STEP:
            begin
                if (!z_reg[34])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_z;
                end
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = S_C_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_C_DONE:
            begin
                if (flip_reg)
                begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                ret_next = S_G1;
                state_next = S_G1;
            end

            // Rotate the local move into the world frame
            S_G1:
            begin
                if (ret_reg != S_G2)
                begin
                    // first entry: dx * cos
                    a_next = 64'(dx_mag);
                    b_next = cos_mag;
                    neg_next = dx_reg[51] ^ x_reg[33];
                    sh_next = SH_ROT;
                    ret_next = S_G2;
                    state_next = S_MUL0;
                end
                else
                begin
                    state_next = S_G2;
                end
            end
            S_G2:
            begin
                if (ret_reg == S_G2)
                begin
                    t_next = sq;
                    a_next = 64'(dy_mag);
                    b_next = sin_mag;
                    neg_next = dy_reg[51] ^ y_reg[33];
                    ret_next = S_G3;
                    state_next = S_MUL0;
                end
                else
                begin
                    state_next = S_G3;
                end
            end
            S_G3:
            begin
                if (ret_reg == S_G3)
                begin
                    g_next = sat48(54'(t_reg) - 54'(sq));
                    a_next = 64'(dx_mag);
                    b_next = sin_mag;
                    neg_next = dx_reg[51] ^ y_reg[33];
                    ret_next = S_G4;
                    state_next = S_MUL0;
                end
                else
                begin
                    state_next = S_G4;
                end
            end
            S_G4:
            begin
                if (ret_reg == S_G4)
                begin
                    px_next = sat48(54'(px_reg) + 54'(g_reg));
                    t_next = sq;
                    a_next = 64'(dy_mag);
                    b_next = cos_mag;
                    neg_next = dy_reg[51] ^ x_reg[33];
                    ret_next = S_G5;
                    state_next = S_MUL0;
                end
                else
                begin
                    state_next = S_G5;
                end
            end
            S_G5:
            begin
                if (ret_reg == S_G5)
                begin
                    g_next = sat48(54'(t_reg) + 54'(sq));
                    ret_next = S_DONE;
                end
                else
                begin
                    py_next = sat48(54'(py_reg) + 54'(g_reg));
                    state_next = S_DONE;
                end
            end

            // Gyro: deadband, step fix-up, |c|*dt then * scale
            S_GY_PREP:
            begin
                a_next = dead ? '0 : 64'(c_abs);
                b_next = dt_fix;
                neg_next = !dead && c_reg[22];
                sh_next = SH_NONE;
                ret_next = S_GY_SCALE;
                state_next = S_MUL0;
            end
            S_GY_SCALE:
            begin
                a_next = q_reg;
                b_next = RATE_SCALE;
                sh_next = SH_YAW;
                ret_next = S_GY_ADD;
                state_next = S_MUL0;
            end
            S_GY_ADD:
            begin
                yaw_next = sat40(54'(yaw_reg) + 54'(sq));
                state_next = S_DONE;
            end

            // Shared multiplier: low half, high half, accumulate, shift and cap
            S_MUL0:
            begin
                mp_next = 64'(mul_in) * 64'(b_reg);
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                p_next = {32'd0, mp_reg};
                mp_next = 64'(mul_in) * 64'(b_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                p_next = p_reg + {mp_reg, 32'd0};
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                if ((sh_reg != SH_NONE) && (p_sh > 96'(PRODUCT_CAP)))
                begin
                    q_next = 64'(PRODUCT_CAP);
                end
                else
                begin
                    q_next = p_sh[63:0];
                end
                state_next = ret_reg;
            end

            // Hold until the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    heading_next = yaw_reg;
                    wx_next = px_reg;
                    wy_next = py_reg;
                    mx_next = lx_reg;
                    my_next = ly_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            wr_reg <= WHEEL_RADIUS_RST;
            rpt_reg <= RAD_PER_TICK_RST;
            bias_reg <= '0;
            db_reg <= DEADBAND_RST;
            for (int i = 0; i < 4; i++)
            begin
                last_cnt_reg[i] <= '0;
            end
            yaw_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            lx_reg <= '0;
            ly_reg <= '0;
            last_t_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            wr_reg <= wr_next;
            rpt_reg <= rpt_next;
            bias_reg <= bias_next;
            db_reg <= db_next;
            for (int i = 0; i < 4; i++)
            begin
                last_cnt_reg[i] <= last_cnt_next[i];
            end
            yaw_reg <= yaw_next;
            px_reg <= px_next;
            py_reg <= py_next;
            lx_reg <= lx_next;
            ly_reg <= ly_next;
            last_t_reg <= last_t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        t_reg <= t_next;
        g_reg <= g_next;
        c_reg <= c_next;
        dt_reg <= dt_next;
        m_reg <= m_next;
        zneg_reg <= zneg_next;
        z_reg <= z_next;
        x_reg <= x_next;
        y_reg <= y_next;
        flip_reg <= flip_next;
        cnt_reg <= cnt_next;
        a_reg <= a_next;
        b_reg <= b_next;
        neg_reg <= neg_next;
        sh_reg <= sh_next;
        mp_reg <= mp_next;
        p_reg <= p_next;
        q_reg <= q_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign heading = heading_reg;
    assign world_x = wx_reg;
    assign world_y = wy_reg;
    assign move_x = mx_reg;
    assign move_y = my_reg;

    `MDR_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE)
    `MDR_ASSERT_NEXT(a_mul_returns, state_reg == S_MUL3, state_reg == $past(ret_reg))
    `MDR_ASSERT_IMP(a_reduce_in_range, state_reg == S_R_SIGN, m_reg < MAG_W'(Q30_TWO_PI))
    `MDR_ASSERT_IMP(a_fold_in_range, (state_reg == S_C_STEP) && (cnt_reg == '0), (z_reg <= Z_HALF) && (z_reg >= -Z_HALF))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the mecanum dead-reckoning pose estimator.
// Depends on mdr_pkg and the mecanum_dead_reckoning_pose RTL; everything else is local.
module tb;
    import mdr_pkg::*;

    localparam int  FRAC        = FRAC_BITS_DEF;
    localparam int  STALL_LIMIT = 3000;   // cycles with no beat on any port
    localparam int  LONG_HOLD   = 600;    // one long receiver hold-off
    localparam int  DRAIN_WAIT  = 200;    // well above the slowest encoder beat

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0][31:0]   counts;
        logic signed [21:0] rate;
        logic [31:0]        stamp;
    } sample_t;

    typedef struct packed {
        logic [39:0] heading;
        logic [47:0] world_x;
        logic [47:0] world_y;
        logic [47:0] move_x;
        logic [47:0] move_y;
    } pose_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_WHEEL_RADIUS;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_CLR_WORLD;
    logic signed [31:0] count_a = '0, count_b = '0, count_c = '0, count_d = '0;
    logic signed [21:0] gyro_rate = '0;
    logic [31:0] timestamp_us = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [39:0] heading;
    logic signed [47:0] world_x, world_y, move_x, move_y;

    mecanum_dead_reckoning_pose #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .count_a(count_a), .count_b(count_b), .count_c(count_c), .count_d(count_d),
        .gyro_rate(gyro_rate), .timestamp_us(timestamp_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .heading(heading), .world_x(world_x), .world_y(world_y),
        .move_x(move_x), .move_y(move_y)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Test-side copy of the configuration and the pose state.
    logic [23:0] radius_q, tick_q;
    logic [15:0] deadband_q;
    longint      bias_q;
    logic [31:0] prev_counts [4];
    logic [31:0] prev_stamp;
    longint      yaw_q, pos_x_q, pos_y_q, trk_x_q, trk_y_q;

    // Generator shadow, runs ahead of acceptance so it keeps its own history.
    logic [31:0] gen_counts [4];
    logic [31:0] gen_stamp;

    sample_t pending_samples [$];
    pose_t   expected_poses  [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    bit  quiet        = 1'b0;   // no idling on either side

    const longint ARCTAN [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543515, 16775851, 8388437, 4194283, 2097149, 1048576,
        524288, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    function automatic longint clamp_to(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Scaled product, truncated toward zero, magnitude capped at 2^50.
    function automatic longint scaled_mult(longint a, longint b, int sh);
        logic [127:0] am, bm, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        am = (a < 0) ? -a : a;
        bm = (b < 0) ? -b : b;
        m = (am * bm) >> sh;
        if (m > 128'(PRODUCT_CAP))
            m = 128'(PRODUCT_CAP);
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // Rotation terms for the current yaw, both Q30.
    function automatic void yaw_cos_sin(input longint yaw, output longint c,
                                        output longint s);
        longint z, x, y, xn, pi_q, two_pi_q, half_pi_q;
        bit flip;
        pi_q = longint'(Q30_PI);
        two_pi_q = longint'(Q30_TWO_PI);
        half_pi_q = longint'(Q30_HALF_PI);
        z = (yaw * (longint'(1) <<< (30 - FRAC))) % two_pi_q;
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > pi_q)
            z -= two_pi_q;
        if (z < -pi_q)
            z += two_pi_q;
        if (z > half_pi_q)
        begin
            z -= pi_q;
            flip = 1'b1;
        end
        else if (z < -half_pi_q)
        begin
            z += pi_q;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARCTAN[i];
            end
            else
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += ARCTAN[i];
            end
            x = xn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Advance the pose by one accepted command and return what the block should report.
    function automatic pose_t advance_pose(sample_t it);
        longint sx, sy, dx, dy, c, s, gx, gy, d, rate_c, mag;
        logic [31:0] u, dt;
        pose_t p;
        sx = 0;
        sy = 0;
        case (it.cmd)
            CMD_ENCODER:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    u = prev_counts[i] - it.counts[i];
                    d = longint'($signed(u));
                    prev_counts[i] = it.counts[i];
                    sx += d;
                    sy += (i == 1 || i == 2) ? -d : d;
                end
                sx *= longint'(tick_q);
                sy *= longint'(tick_q);
                dx = scaled_mult(sx, longint'(radius_q), FRAC + 2);
                dy = scaled_mult(sy, longint'(radius_q), FRAC + 2);
                trk_x_q = clamp_to(trk_x_q + dx, 48);
                trk_y_q = clamp_to(trk_y_q + dy, 48);
                yaw_cos_sin(yaw_q, c, s);
                gx = clamp_to(scaled_mult(dx, c, 30) - scaled_mult(dy, s, 30), 48);
                gy = clamp_to(scaled_mult(dx, s, 30) + scaled_mult(dy, c, 30), 48);
                pos_x_q = clamp_to(pos_x_q + gx, 48);
                pos_y_q = clamp_to(pos_y_q + gy, 48);
            end
            CMD_GYRO:
            begin
                rate_c = longint'(it.rate) - bias_q;
                mag = (rate_c < 0) ? -rate_c : rate_c;
                dt = it.stamp - prev_stamp;
                if (dt == 0 || dt > DT_LIMIT)
                    dt = DT_DEFAULT;
                prev_stamp = it.stamp;
                if (mag < longint'(deadband_q))
                    rate_c = 0;
                yaw_q = clamp_to(yaw_q + scaled_mult(rate_c * longint'(dt),
                                 longint'(RATE_SCALE), 60 - FRAC), 40);
            end
            CMD_CLR_WORLD:
            begin
                pos_x_q = 0;
                pos_y_q = 0;
            end
            default:
            begin
                trk_x_q = 0;
                trk_y_q = 0;
            end
        endcase
        p.heading = yaw_q[39:0];
        p.world_x = pos_x_q[47:0];
        p.world_y = pos_y_q[47:0];
        p.move_x  = trk_x_q[47:0];
        p.move_y  = trk_y_q[47:0];
        return p;
    endfunction

    // Mostly plausible motion; now and then raw noise or a stale/late timestamp.
    function automatic sample_t random_sample();
        sample_t it;
        int pick;
        it = '0;
        pick = $urandom_range(0, 99);
        it.rate = 22'($urandom);
        it.stamp = $urandom;
        for (int i = 0; i < 4; i++)
            it.counts[i] = $urandom;
        if (pick < 50)
        begin
            it.cmd = CMD_ENCODER;
            if ($urandom_range(0, 9) != 0)
                for (int i = 0; i < 4; i++)
                    it.counts[i] = gen_counts[i] + 32'($urandom_range(0, 800)) - 32'd400;
            for (int i = 0; i < 4; i++)
                gen_counts[i] = it.counts[i];
        end
        else if (pick < 85)
        begin
            it.cmd = CMD_GYRO;
            case ($urandom_range(0, 9))
                0: it.stamp = gen_stamp;
                1: ;
                2: it.stamp = gen_stamp + 32'd500000 + 32'($urandom_range(0, 2));
                default: it.stamp = gen_stamp + 32'($urandom_range(1000, 40000));
            endcase
            if ($urandom_range(0, 4) != 0)
                it.rate = 22'($urandom_range(0, 60000)) - 22'sd30000;
            gen_stamp = it.stamp;
        end
        else if (pick < 93)
            it.cmd = CMD_CLR_WORLD;
        else
            it.cmd = CMD_CLR_MOVE;
        return it;
    endfunction

    function automatic sample_t enc_sample(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
        sample_t it;
        it = '0;
        it.cmd = CMD_ENCODER;
        it.counts = {d, c, b, a};
        gen_counts = '{a, b, c, d};
        return it;
    endfunction

    function automatic sample_t gyro_sample(logic signed [21:0] r, logic [31:0] ts);
        sample_t it;
        it = '0;
        it.cmd = CMD_GYRO;
        it.rate = r;
        it.stamp = ts;
        gen_stamp = ts;
        return it;
    endfunction

    // Driver: hold the beat until accepted, predict at acceptance, idle in bursts.
    int send_gap  = 0;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sample_t it;
        bit next_valid;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                it.cmd = command;
                it.counts = {count_d, count_c, count_b, count_a};
                it.rate = gyro_rate;
                it.stamp = timestamp_us;
                expected_poses.push_back(advance_pose(it));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_calm > 0)
                    send_calm--;
                else if (!quiet && $urandom_range(0, 99) == 0)
                    send_calm = $urandom_range(50, 300);
                if (send_gap > 0)
                    send_gap--;
                else if (pending_samples.size() > 0)
                begin
                    it = pending_samples.pop_front();
                    command <= it.cmd;
                    count_a <= it.counts[0];
                    count_b <= it.counts[1];
                    count_c <= it.counts[2];
                    count_d <= it.counts[3];
                    gyro_rate <= it.rate;
                    timestamp_us <= it.stamp;
                    next_valid = 1'b1;
                    if (!quiet && send_calm == 0 && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 12);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: compare each result beat with the oldest prediction; stall the output.
    int  recv_gap  = 0;
    int  recv_calm = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_poses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with nothing outstanding",
                                 results_seen);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (want.heading !== heading || want.world_x !== world_x ||
                        want.world_y !== world_y || want.move_x !== move_x ||
                        want.move_y !== move_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("beat %0d expected hd=%h wx=%h wy=%h mx=%h my=%h",
                                     results_seen, want.heading, want.world_x,
                                     want.world_y, want.move_x, want.move_y);
                            $display("beat %0d actual   hd=%h wx=%h wy=%h mx=%h my=%h",
                                     results_seen, heading, world_x, world_y,
                                     move_x, move_y);
                        end
                    end
                end
            end
            // One long hold-off so the block backs up into its input.
            if (!held_once && results_seen == 150)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (recv_calm > 0)
                recv_calm--;
            else if (!quiet && $urandom_range(0, 99) == 0)
                recv_calm = $urandom_range(50, 300);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!quiet && recv_calm == 0 && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no beat moves on any port for too long.
    int dead_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_WHEEL_RADIUS: radius_q = value;
            REG_RAD_PER_TICK: tick_q = value;
            REG_GYRO_BIAS:    bias_q = longint'($signed(value[21:0]));
            default:          deadband_q = value[15:0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold off until the block has drained every outstanding command; sample at the
    // falling edge so the driver's updates from the last rising edge have settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || expected_poses.size() != 0 || in_valid);
    endtask

    task automatic load_random(input int n);
        for (int i = 0; i < n; i++)
            pending_samples.push_back(random_sample());
    endtask

    task automatic load_config(input logic [23:0] r, input logic [23:0] t,
                               input logic [23:0] b, input logic [23:0] db);
        write_reg(REG_WHEEL_RADIUS, r);
        write_reg(REG_RAD_PER_TICK, t);
        write_reg(REG_GYRO_BIAS, b);
        write_reg(REG_GYRO_DEADBAND, db);
    endtask

    initial
    begin
        sample_t it;
        radius_q = WHEEL_RADIUS_RST;
        tick_q = RAD_PER_TICK_RST;
        bias_q = 0;
        deadband_q = DEADBAND_RST;
        prev_counts = '{default: '0};
        gen_counts = '{default: '0};
        prev_stamp = '0;
        gen_stamp = '0;
        yaw_q = 0;
        pos_x_q = 0;
        pos_y_q = 0;
        trk_x_q = 0;
        trk_y_q = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset defaults: wraps, deadband edges, step limits, clears.
        pending_samples.push_back(enc_sample(0, 0, 0, 0));
        pending_samples.push_back(enc_sample(100, 200, -50, 7));
        pending_samples.push_back(enc_sample(32'h7FFFFFFF, 32'h7FFFFFFF,
                                             32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_samples.push_back(enc_sample(32'h80000000, 32'h80000000,
                                             32'h80000000, 32'h80000000));
        pending_samples.push_back(enc_sample(32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF));
        pending_samples.push_back(gyro_sample(22'sd1000, 32'd0));
        pending_samples.push_back(gyro_sample(22'sd153, 32'd10000));
        pending_samples.push_back(gyro_sample(-22'sd154, 32'd30000));
        pending_samples.push_back(gyro_sample(22'sh1FFFFF, 32'd630000));
        pending_samples.push_back(gyro_sample(22'sh200000, 32'hFFFFFFF0));
        pending_samples.push_back(gyro_sample(22'sd2047999, 32'h00000100));
        pending_samples.push_back(gyro_sample(-22'sd2048000, 32'h00000100 + 32'd500000));
        pending_samples.push_back(enc_sample(50, 150, -100, 40));
        it = '0;
        it.cmd = CMD_CLR_WORLD;
        pending_samples.push_back(it);
        pending_samples.push_back(enc_sample(-300, 500, 20, 900));
        it.cmd = CMD_CLR_MOVE;
        pending_samples.push_back(it);
        pending_samples.push_back(gyro_sample(22'sd0, 32'h00000100 + 32'd520000));
        pending_samples.push_back(enc_sample(-250, 420, 60, 1000));
        wait_drained();

        // Mid-range setting; the long hold-off lands in this phase.
        load_config(24'($urandom_range(100000, 2000000)), 24'($urandom_range(1000, 100000)),
                    24'($urandom_range(0, 4000)) - 24'd2000, 24'($urandom_range(0, 2000)));
        load_random(300);
        wait_drained();

        // Top extremes: positions run into saturation.
        load_config(24'hFFFFFF, 24'hFFFFFF, 24'h200000, 24'h00FFFF);
        load_random(200);
        wait_drained();

        // Bottom extremes: no travel, no deadband.
        load_config(24'h000000, 24'h000000, 24'h1FFFFF, 24'h000000);
        load_random(150);
        wait_drained();

        load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        load_random(300);
        wait_drained();

        // Closing stretch with no idling on either side.
        quiet = 1'b1;
        load_config(WHEEL_RADIUS_RST, RAD_PER_TICK_RST, 24'd0, 24'(DEADBAND_RST));
        load_random(150);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
